// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is low.
`define CBT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds during reset.
`define CBT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/cbt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cbt_pkg;

    // Largest sample exponent; a segment gives at most MAX_N samples.
    localparam int MAX_LOG2_SAMPLES = 4;
    localparam int MAX_N            = 1 << MAX_LOG2_SAMPLES;

    localparam int LOG_W      = 3;
    localparam logic [LOG_W-1:0] LOG2_RESET = LOG_W'(4);

    localparam int PT_W  = 12;                         // control point coordinate
    localparam int G_W   = PT_W + 2;                   // geometry value, phantom points included
    localparam int K_W   = MAX_LOG2_SAMPLES;           // sample index
    localparam int WGT_W = 3 * MAX_LOG2_SAMPLES + 3;   // basis weight, at most 4*N^3
    localparam int P_W   = WGT_W + 1 + G_W;            // weight times coordinate
    localparam int S_W   = P_W + 2;                    // sum of four products
    localparam int NUM_W = S_W + 6;                    // 32*sum plus the rounding term
    localparam int SHIFT = 3 * MAX_LOG2_SAMPLES + 2;   // power-of-two part of 2*6*N^3

    // The divided value lies well within +-2^20 for every input pattern.
    localparam int T_W   = 21;
    localparam int U_W   = T_W + 1;
    localparam int RCP_W = U_W - 1;
    localparam int OUT_W = 18;

    // Denominator 6*N^3 = 3*2^(3L+1), added once as the round-half-up term.
    localparam logic signed [NUM_W-1:0] DEN = NUM_W'(3) << (3 * MAX_LOG2_SAMPLES + 1);

    // Floor division by three: bias to a non-negative value, multiply by the
    // reciprocal, then one compare and increment.
    localparam logic [RCP_W-1:0] RCP      = RCP_W'((64'd1 << U_W) / 64'd3);
    localparam logic [U_W-1:0]   DIV_OFS  = U_W'(3) << (T_W - 1);
    localparam logic [U_W-1:0]   DIV_BIAS = U_W'(1) << (T_W - 1);

    // Segment codes.
    localparam logic [1:0] SEG_START = 2'd0;
    localparam logic [1:0] SEG_MAIN  = 2'd1;
    localparam logic [1:0] SEG_END   = 2'd2;

    typedef logic [3:0][WGT_W-1:0] wgt_set_t;

    typedef struct packed {
        logic           load;    // capture the incoming control point
        logic           issue;   // start one sample in the evaluator
        logic [1:0]     seg;     // segment being sampled
        logic [K_W-1:0] idx;     // sample position in steps of 1/MAX_N
        logic           eor;     // this sample closes the transfer's results
        logic           shift;   // move the new point into the window
    } cbt_cmd_t;

    // Uniform cubic B-spline weights at u = idx/MAX_N, scaled by 6*MAX_N^3.
    function automatic wgt_set_t bspline_weights(input logic [K_W-1:0] idx);
        int       k;
        int       n;
        wgt_set_t r;
        k = int'(idx);
        n = MAX_N;
        r[0] = WGT_W'((n - k) * (n - k) * (n - k));
        r[1] = WGT_W'(3 * k * k * k - 6 * k * k * n + 4 * n * n * n);
        r[2] = WGT_W'(-3 * k * k * k + 3 * k * k * n + 3 * k * n * n + n * n * n);
        r[3] = WGT_W'(k * k * k);
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cbt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbt_ctrl import cbt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             last_point,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [LOG_W-1:0] cfg_data,
    input  wire logic             advance,
    output cbt_cmd_t              cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [2:0]       seen_reg, seen_next;
    logic             last_reg, last_next;
    logic [1:0]       seg_reg, seg_next;
    logic [K_W-1:0]   k_reg, k_next;
    logic [LOG_W-1:0] lg_reg, lg_next;

    logic [LOG_W-1:0] eff_lg;
    logic [K_W-1:0]   k_max;
    logic             finish;

    assign eff_lg    = (lg_reg > LOG_W'(MAX_LOG2_SAMPLES)) ? LOG_W'(MAX_LOG2_SAMPLES) : lg_reg;
    assign k_max     = K_W'((32'd1 << eff_lg) - 32'd1);
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        seen_next  = seen_reg;
        last_next  = last_reg;
        seg_next   = seg_reg;
        k_next     = k_reg;
        lg_next    = cfg_valid ? cfg_data : lg_reg;
        finish     = 1'b0;
        cmd        = '0;
        cmd.seg    = seg_reg;
        cmd.idx    = k_reg << (LOG_W'(MAX_LOG2_SAMPLES) - eff_lg);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    last_next  = last_point;
                    seg_next   = (seen_reg == 3'd3) ? SEG_START : SEG_MAIN;
                    k_next     = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (seen_reg < 3'd3)
                begin
                    finish = 1'b1;
                end
                else if (advance)
                begin
                    cmd.issue = 1'b1;
                    if (k_reg == k_max)
                    begin
                        k_next = '0;
                        if (seg_reg == SEG_START)
                        begin
                            seg_next = SEG_MAIN;
                        end
                        else if (seg_reg == SEG_MAIN && last_reg)
                        begin
                            seg_next = SEG_END;
                        end
                        else
                        begin
                            finish  = 1'b1;
                            cmd.eor = 1'b1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + K_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next = ST_IDLE;
            cmd.shift  = !last_reg;
            if (last_reg)
            begin
                seen_next = 3'd0;
            end
            else if (seen_reg != 3'd4)
            begin
                seen_next = seen_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seen_reg  <= 3'd0;
            last_reg  <= 1'b0;
            seg_reg   <= SEG_MAIN;
            k_reg     <= '0;
            lg_reg    <= LOG2_RESET;
        end
        else
        begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            last_reg  <= last_next;
            seg_reg   <= seg_next;
            k_reg     <= k_next;
            lg_reg    <= lg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cbt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cbt_datapath import cbt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic signed [PT_W-1:0]  point_x,
    input  wire logic signed [PT_W-1:0]  point_y,
    input  wire cbt_cmd_t                cmd,
    output logic                         advance,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [OUT_W-1:0]      curve_x,
    output logic signed [OUT_W-1:0]      curve_y,
    output logic                         end_of_run
);

    function automatic logic signed [G_W-1:0] gext(input logic signed [PT_W-1:0] a);
        return G_W'(a);
    endfunction

    // Window of the last three points, oldest first, and the new point.
    logic signed [PT_W-1:0] win_x_reg [3];
    logic signed [PT_W-1:0] win_y_reg [3];
    logic signed [PT_W-1:0] cur_x_reg, cur_y_reg;

    logic signed [G_W-1:0]  gx_c [4];
    logic signed [G_W-1:0]  gy_c [4];

    // Pipeline: geometry and weights, products, sums, reciprocal product, output.
    logic                   v1_reg, v2_reg, v3_reg, v4_reg, out_valid_reg;
    logic                   e1_reg, e2_reg, e3_reg, e4_reg, eor_reg;
    logic signed [G_W-1:0]  gx_reg [4];
    logic signed [G_W-1:0]  gy_reg [4];
    wgt_set_t               w_reg;
    logic signed [P_W-1:0]  px_reg [4];
    logic signed [P_W-1:0]  py_reg [4];
    logic signed [T_W-1:0]  tx_reg, ty_reg;
    logic [U_W-1:0]         ux_reg, uy_reg;
    logic [RCP_W-1:0]       qx_reg, qy_reg;
    logic signed [OUT_W-1:0] curve_x_reg, curve_y_reg;

    logic signed [S_W-1:0]   sx_c, sy_c;
    logic signed [NUM_W-1:0] nx_c, ny_c, nx_sh, ny_sh;
    logic [U_W-1:0]          ux_c, uy_c;
    logic [U_W+RCP_W-1:0]    mx_c, my_c;
    logic [U_W-1:0]          rx_c, ry_c, fx_c, fy_c;

    assign advance = !(out_valid_reg && out_stall);

    always_comb
    begin
        case (cmd.seg)
            SEG_START:
            begin
                gx_c[0] = (gext(win_x_reg[0]) <<< 1) - gext(win_x_reg[1]);
                gy_c[0] = (gext(win_y_reg[0]) <<< 1) - gext(win_y_reg[1]);
                gx_c[1] = gext(win_x_reg[0]);
                gy_c[1] = gext(win_y_reg[0]);
                gx_c[2] = gext(win_x_reg[1]);
                gy_c[2] = gext(win_y_reg[1]);
                gx_c[3] = gext(win_x_reg[2]);
                gy_c[3] = gext(win_y_reg[2]);
            end
            SEG_END:
            begin
                gx_c[0] = gext(win_x_reg[1]);
                gy_c[0] = gext(win_y_reg[1]);
                gx_c[1] = gext(win_x_reg[2]);
                gy_c[1] = gext(win_y_reg[2]);
                gx_c[2] = gext(cur_x_reg);
                gy_c[2] = gext(cur_y_reg);
                gx_c[3] = (gext(cur_x_reg) <<< 1) - gext(win_x_reg[2]);
                gy_c[3] = (gext(cur_y_reg) <<< 1) - gext(win_y_reg[2]);
            end
            default:
            begin
                gx_c[0] = gext(win_x_reg[0]);
                gy_c[0] = gext(win_y_reg[0]);
                gx_c[1] = gext(win_x_reg[1]);
                gy_c[1] = gext(win_y_reg[1]);
                gx_c[2] = gext(win_x_reg[2]);
                gy_c[2] = gext(win_y_reg[2]);
                gx_c[3] = gext(cur_x_reg);
                gy_c[3] = gext(cur_y_reg);
            end
        endcase
    end

    // Round half up of 16*sum/(6*N^3), first the power-of-two part of the divisor.
    always_comb
    begin
        sx_c  = S_W'(px_reg[0]) + S_W'(px_reg[1]) + S_W'(px_reg[2]) + S_W'(px_reg[3]);
        sy_c  = S_W'(py_reg[0]) + S_W'(py_reg[1]) + S_W'(py_reg[2]) + S_W'(py_reg[3]);
        nx_c  = (NUM_W'(sx_c) <<< 5) + DEN;
        ny_c  = (NUM_W'(sy_c) <<< 5) + DEN;
        nx_sh = nx_c >>> SHIFT;
        ny_sh = ny_c >>> SHIFT;
    end

    // Then the floor division by three.
    always_comb
    begin
        ux_c = U_W'(tx_reg) + DIV_OFS;
        uy_c = U_W'(ty_reg) + DIV_OFS;
        mx_c = {{RCP_W{1'b0}}, ux_c} * {{U_W{1'b0}}, RCP};
        my_c = {{RCP_W{1'b0}}, uy_c} * {{U_W{1'b0}}, RCP};
        rx_c = ux_reg - ((U_W'(qx_reg) << 1) + U_W'(qx_reg));
        ry_c = uy_reg - ((U_W'(qy_reg) << 1) + U_W'(qy_reg));
        fx_c = U_W'(qx_reg) + U_W'(rx_c >= U_W'(3)) - DIV_BIAS;
        fy_c = U_W'(qy_reg) + U_W'(ry_c >= U_W'(3)) - DIV_BIAS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                win_x_reg[i] <= '0;
                win_y_reg[i] <= '0;
            end
        end
        else
        begin
            if (advance)
            begin
                v1_reg        <= cmd.issue;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                out_valid_reg <= v4_reg;
            end
            if (cmd.shift)
            begin
                win_x_reg[0] <= win_x_reg[1];
                win_y_reg[0] <= win_y_reg[1];
                win_x_reg[1] <= win_x_reg[2];
                win_y_reg[1] <= win_y_reg[2];
                win_x_reg[2] <= cur_x_reg;
                win_y_reg[2] <= cur_y_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg <= point_x;
            cur_y_reg <= point_y;
        end
        if (advance)
        begin
            e1_reg <= cmd.eor;
            e2_reg <= e1_reg;
            e3_reg <= e2_reg;
            e4_reg <= e3_reg;
            eor_reg <= e4_reg;
            w_reg  <= bspline_weights(cmd.idx);
            for (int i = 0; i < 4; i++)
            begin
                gx_reg[i] <= gx_c[i];
                gy_reg[i] <= gy_c[i];
                px_reg[i] <= P_W'($signed({1'b0, w_reg[i]})) * P_W'(gx_reg[i]);
                py_reg[i] <= P_W'($signed({1'b0, w_reg[i]})) * P_W'(gy_reg[i]);
            end
            tx_reg      <= nx_sh[T_W-1:0];
            ty_reg      <= ny_sh[T_W-1:0];
            ux_reg      <= ux_c;
            uy_reg      <= uy_c;
            qx_reg      <= mx_c[U_W+RCP_W-1:U_W];
            qy_reg      <= my_c[U_W+RCP_W-1:U_W];
            curve_x_reg <= fx_c[OUT_W-1:0];
            curve_y_reg <= fy_c[OUT_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign curve_x    = curve_x_reg;
    assign curve_y    = curve_y_reg;
    assign end_of_run = eor_reg;

endmodule

`default_nettype wire

// ===== hdl/cubic_bspline_tessellator.sv =====
// Uniform cubic B-spline tessellator. Control points enter one per input
// transfer and leave as curve samples in sixteenths of a pixel, rounded to
// nearest with halves going up. A run of points ends with a point that has
// last_point set; runs of fewer than four points give no samples. The fourth
// point of a run yields a start segment followed by the first regular
// segment, each later point yields one segment, and the last point of a long
// enough run adds an end segment, so one point gives 0, 1, 2 or 3 segments of
// 2^log2_samples samples each. end_of_run marks the final sample caused by a
// point. log2_samples is set through the configuration channel (ready is always
// high), resets to 4 and is clipped to 4; write it only while no samples are
// outstanding. A point holds the input stalled after its transfer until its last
// sample has started, because one shared evaluator starts one sample per cycle
// while the output does not stall; a new point is accepted in the cycle after
// the last sample starts. Samples pass through the five-stage evaluator
// pipeline, and an output stall freezes that whole pipeline.
`timescale 1ns / 1ps
`default_nettype none

module cubic_bspline_tessellator import cbt_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,

    // Control point channel.
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [PT_W-1:0]  point_x,
    input  wire logic signed [PT_W-1:0]  point_y,
    input  wire logic                    last_point,

    // Curve sample channel.
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [OUT_W-1:0]      curve_x,
    output logic signed [OUT_W-1:0]      curve_y,
    output logic                         end_of_run,

    // Configuration channel for log2_samples.
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [LOG_W-1:0]        cfg_data
);

    // The controller tracks the run, sequences segments and sample positions,
    // and issues one command per cycle, holding back samples while the output
    // stalls; the datapath holds the point window and evaluates samples.
    cbt_cmd_t cmd;
    logic     advance;

    cbt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .last_point (last_point),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .advance    (advance),
        .cmd        (cmd)
    );

    // The datapath computes each sample as a weighted sum of four geometry
    // points with weights scaled to the finest sample grid, then divides by
    // the fixed denominator with a shift and a reciprocal multiplication.
    cbt_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .point_x    (point_x),
        .point_y    (point_y),
        .cmd        (cmd),
        .advance    (advance),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .curve_x    (curve_x),
        .curve_y    (curve_y),
        .end_of_run (end_of_run)
    );

endmodule

`default_nettype wire

// ===== hdl/cbt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cbt_checker import cbt_pkg::*;
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic signed [OUT_W-1:0] curve_x,
    input wire logic signed [OUT_W-1:0] curve_y,
    input wire logic                    end_of_run
);

    // A held sample stays put until it is taken.
    `CBT_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(curve_x) && $stable(curve_y) && $stable(end_of_run), "stalled sample changed")

    // After a point transfer the block is busy with that point.
    `CBT_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall |=> in_stall, "second point accepted back to back")

    // Samples of one point follow each other without gaps.
    `CBT_ASSERT(a_no_gap, clk, rst_n, out_valid && !out_stall && !end_of_run |=> out_valid, "gap inside a sample burst")

    // Reset leaves no sample on the output.
    `CBT_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "sample present after reset")

endmodule

bind cubic_bspline_tessellator cbt_checker u_cbt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .curve_x    (curve_x),
    .curve_y    (curve_y),
    .end_of_run (end_of_run)
);

`default_nettype wire
